### rtl/mhpq_pkg.sv
package mhpq_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLD_RD,
        S_BLD_LD,
        S_POP_RD,
        S_POP_LD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_DONE
    } t_state;

    typedef enum logic {
        M_BUILD,
        M_POP
    } t_mode;

endpackage

### rtl/mhpq_ram.sv
module mhpq_ram #(
    parameter int DEPTH      = mhpq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr_a,
    input  logic [AW-1:0]         i_raddr_b,
    output logic [DATA_WIDTH-1:0] o_rdata_a,
    output logic [DATA_WIDTH-1:0] o_rdata_b
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/max_heap_priority_queue_top.sv
// max-heap priority queue over an on-chip store of DEPTH signed entries
// input channel: i_in_valid / o_in_stall carry one beat of i_action and
// i_value. action load appends the value unordered, action pop removes the
// largest entry. a pop of an empty heap reports status empty, a load into a
// full store reports status full and drops the value.
// output channel: o_out_valid / i_out_stall carry one result beat per input
// beat: o_popped (zero unless a pop succeeded), o_status, o_occupancy.
// throughput: one beat at a time. a load writes the value and finishes. a pop
// on an ordered heap reads the root and the last entry, then runs the
// sift-down loop: each level reads both children from the dual-read store,
// then compares and writes back.
// the first pop after loads rebuilds the heap bottom-up first, adding, for
// each of the n/2 inner nodes, a read of that node plus one sift-down.
// o_in_stall is high from acceptance until the result enters the output
// register; a new beat is taken while that result waits for the receiver.
// while i_out_stall is high the result beat holds, and a finished next
// result waits inside until the register frees up.
// reset (synchronous, active low) empties the heap and the output register;
// the store itself is not cleared.
module max_heap_priority_queue_top #(
    parameter int DEPTH      = mhpq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DATA_WIDTH-1:0] o_popped,
    output logic [1:0]            o_status,
    output logic [CW-1:0]         o_occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = AW + 2;

    mhpq_pkg::t_state r_state, n_state;
    mhpq_pkg::t_mode  r_mode, n_mode;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_ordered, n_ordered;
    logic [AW-1:0]         r_k, n_k;
    logic [AW-1:0]         r_node, n_node;
    logic [DATA_WIDTH-1:0] r_x, n_x;
    logic [DATA_WIDTH-1:0] r_res_popped, n_res_popped;
    logic [1:0]            r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_out_popped, n_out_popped;
    logic [1:0]            r_out_status, n_out_status;
    logic [CW-1:0]         r_out_occ, n_out_occ;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [AW-1:0]         raddr_a, raddr_b;
    logic [DATA_WIDTH-1:0] rdata_a, rdata_b;

    logic [XW-1:0] left_idx, right_idx, cnt_x;
    logic          left_ok, right_ok;
    logic          take_left, take_right;
    logic [DATA_WIDTH-1:0] big_l;
    logic          sift_end;

    mhpq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign left_idx  = {1'b0, r_node, 1'b1};
    assign right_idx = left_idx + XW'(1);
    assign cnt_x     = XW'(r_count);
    assign left_ok   = left_idx < cnt_x;
    assign right_ok  = right_idx < cnt_x;
    assign take_left = left_ok && ($signed(rdata_a) > $signed(r_x));
    assign big_l     = take_left ? rdata_a : r_x;
    assign take_right = right_ok && ($signed(rdata_b) > $signed(big_l));

    assign o_in_stall  = (r_state != mhpq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_popped    = r_out_popped;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhpq_pkg::S_IDLE;
            r_mode      <= mhpq_pkg::M_POP;
            r_count     <= '0;
            r_ordered   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_ordered   <= n_ordered;
            r_out_valid <= n_out_valid;
        end
        r_k          <= n_k;
        r_node       <= n_node;
        r_x          <= n_x;
        r_res_popped <= n_res_popped;
        r_res_status <= n_res_status;
        r_out_popped <= n_out_popped;
        r_out_status <= n_out_status;
        r_out_occ    <= n_out_occ;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_count      = r_count;
        n_ordered    = r_ordered;
        n_k          = r_k;
        n_node       = r_node;
        n_x          = r_x;
        n_res_popped = r_res_popped;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_popped = r_out_popped;
        n_out_status = r_out_status;
        n_out_occ    = r_out_occ;
        we           = 1'b0;
        waddr        = r_node;
        wdata        = r_x;
        raddr_a      = left_idx[AW-1:0];
        raddr_b      = right_idx[AW-1:0];
        sift_end     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_res_popped = '0;
                    n_res_status = mhpq_pkg::ST_OK;
                    n_state      = mhpq_pkg::S_DONE;
                    if (i_action == mhpq_pkg::ACT_LOAD) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_res_status = mhpq_pkg::ST_FULL;
                        end else begin
                            we        = 1'b1;
                            waddr     = r_count[AW-1:0];
                            wdata     = i_value;
                            n_count   = r_count + CW'(1);
                            n_ordered = 1'b0;
                        end
                    end else if (r_count == '0) begin
                        n_res_status = mhpq_pkg::ST_EMPTY;
                    end else if (!r_ordered && r_count >= CW'(2)) begin
                        n_k     = AW'((r_count >> 1) - CW'(1));
                        n_state = mhpq_pkg::S_BLD_RD;
                    end else begin
                        n_ordered = 1'b1;
                        n_state   = mhpq_pkg::S_POP_RD;
                    end
                end
            end
            mhpq_pkg::S_BLD_RD: begin
                raddr_a = r_k;
                n_state = mhpq_pkg::S_BLD_LD;
            end
            mhpq_pkg::S_BLD_LD: begin
                n_x     = rdata_a;
                n_node  = r_k;
                n_mode  = mhpq_pkg::M_BUILD;
                n_state = mhpq_pkg::S_SIFT_RD;
            end
            mhpq_pkg::S_POP_RD: begin
                raddr_a = '0;
                raddr_b = AW'(r_count - CW'(1));
                n_state = mhpq_pkg::S_POP_LD;
            end
            mhpq_pkg::S_POP_LD: begin
                n_res_popped = rdata_a;
                n_res_status = mhpq_pkg::ST_OK;
                n_x          = rdata_b;
                n_node       = '0;
                n_mode       = mhpq_pkg::M_POP;
                n_count      = r_count - CW'(1);
                if (r_count == CW'(1)) begin
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    n_state = mhpq_pkg::S_SIFT_RD;
                end
            end
            mhpq_pkg::S_SIFT_RD: begin
                if (!left_ok) begin
                    we       = 1'b1;
                    sift_end = 1'b1;
                end else begin
                    n_state = mhpq_pkg::S_SIFT_CMP;
                end
            end
            mhpq_pkg::S_SIFT_CMP: begin
                we = 1'b1;
                if (take_right) begin
                    wdata   = rdata_b;
                    n_node  = right_idx[AW-1:0];
                    n_state = mhpq_pkg::S_SIFT_RD;
                end else if (take_left) begin
                    wdata   = rdata_a;
                    n_node  = left_idx[AW-1:0];
                    n_state = mhpq_pkg::S_SIFT_RD;
                end else begin
                    sift_end = 1'b1;
                end
            end
            mhpq_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_popped = r_res_popped;
                    n_out_status = r_res_status;
                    n_out_occ    = r_count;
                    n_state      = mhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::S_IDLE;
            end
        endcase

        if (sift_end) begin
            if (r_mode == mhpq_pkg::M_POP) begin
                n_state = mhpq_pkg::S_DONE;
            end else if (r_k == '0) begin
                n_ordered = 1'b1;
                n_state   = mhpq_pkg::S_POP_RD;
            end else begin
                n_k     = r_k - AW'(1);
                n_state = mhpq_pkg::S_BLD_RD;
            end
        end
    end

endmodule
